### sv/multi_fan_tachometer_assert.svh
// assertion macros shared by the tachometer rtl
`ifndef MULTI_FAN_TACHOMETER_ASSERT_SVH
`define MULTI_FAN_TACHOMETER_ASSERT_SVH

`ifndef SYNTHESIS
// concurrent check, quiet while reset is high
`define MFT_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");
// concurrent check that also runs through reset
`define MFT_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("%m: check failed");
`else
`define MFT_ASSERT(label, clk, rst, prop)
`define MFT_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

### sv/mft_pkg.sv
package mft_pkg;

   // sizes
   localparam int NUM_FANS     = 5;
   localparam int FAN_BITS     = 3;
   localparam int TIME_BITS    = 48;
   localparam int LIMIT_W      = 24;
   localparam int NUM_W        = 32;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DATA_W   = 32;

   // divider step counter
   localparam int DIV_STEP_BITS = $clog2(NUM_W);

   // queue between front and back, depth is a power of two
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   // operation codes
   localparam logic OP_EDGE = 1'b0;
   localparam logic OP_READ = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_INTERVAL = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_AGE      = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_NUMERATOR    = 2'd2;

   // register reset values
   localparam logic [LIMIT_W-1:0] MIN_INTERVAL_RESET = 24'd1250;
   localparam logic [LIMIT_W-1:0] MAX_AGE_RESET      = 24'd1000000;
   localparam logic [NUM_W-1:0]   NUMERATOR_RESET    = 32'd15000000;

   // work handed from front to back
   typedef struct packed {
      logic               rd_div;
      logic               accepted;
      logic [LIMIT_W-1:0] divisor;
   } job_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_DONE
   } back_state_type;

endpackage

### sv/mft_req_if.sv
interface mft_req_if;
   import mft_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 operation;
   logic [FAN_BITS-1:0]  fan_index;
   logic [TIME_BITS-1:0] timestamp_us;

   modport source (output valid, operation, fan_index, timestamp_us, input ready);
   modport sink (input valid, operation, fan_index, timestamp_us, output ready);
endinterface

### sv/mft_rsp_if.sv
interface mft_rsp_if;
   import mft_pkg::*;

   logic             valid;
   logic             ready;
   logic             edge_accepted;
   logic [NUM_W-1:0] rpm;

   modport source (output valid, edge_accepted, rpm, input ready);
   modport sink (input valid, edge_accepted, rpm, output ready);
endinterface

### sv/mft_front.sv
module mft_front (
   input  logic                            clock,
   input  logic                            reset,
   mft_req_if.sink                         req_bus,
   input  logic [mft_pkg::LIMIT_W-1:0]     min_interval,
   input  logic [mft_pkg::LIMIT_W-1:0]     max_age,
   input  logic                            queue_full,
   output logic                            push_valid,
   output mft_pkg::job_type                push_job
);
   import mft_pkg::*;

   logic [TIME_BITS-1:0] last_edge_ff [NUM_FANS];
   logic [TIME_BITS-1:0] last_edge_in [NUM_FANS];
   logic [TIME_BITS-1:0] interval_ff  [NUM_FANS];
   logic [TIME_BITS-1:0] interval_in  [NUM_FANS];
   logic                 fire;
   logic                 fan_ok;
   logic [FAN_BITS-1:0]  idx;
   logic [TIME_BITS-1:0] delta;
   logic [TIME_BITS-1:0] iv;
   logic [TIME_BITS-1:0] min_ext;
   logic [TIME_BITS-1:0] max_ext;

   // take a transaction whenever the queue has room
   assign req_bus.ready = !queue_full;
   assign fire          = req_bus.valid && req_bus.ready;

   // channel lookup, out-of-range fans read channel zero and are masked
   assign fan_ok  = req_bus.fan_index < FAN_BITS'(NUM_FANS);
   assign idx     = fan_ok ? req_bus.fan_index : '0;
   assign delta   = req_bus.timestamp_us - last_edge_ff[idx];
   assign iv      = interval_ff[idx];
   assign min_ext = TIME_BITS'(min_interval);
   assign max_ext = TIME_BITS'(max_age);

   // classify the transaction
   always_comb begin
      push_valid        = fire;
      push_job.accepted = (req_bus.operation == OP_EDGE) && fan_ok && (delta >= min_ext);
      push_job.rd_div   = (req_bus.operation == OP_READ) && fan_ok && (iv != '0)
                          && (iv < max_ext) && (delta < max_ext);
      push_job.divisor  = iv[LIMIT_W-1:0];
   end

   // channel state update on an accepted edge
   always_comb begin
      last_edge_in = last_edge_ff;
      interval_in  = interval_ff;
      if (fire && push_job.accepted) begin
         last_edge_in[idx] = req_bus.timestamp_us;
         interval_in[idx]  = delta;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_FANS; i++) begin
            last_edge_ff[i] <= '0;
            interval_ff[i]  <= '0;
         end
      end else begin
         last_edge_ff <= last_edge_in;
         interval_ff  <= interval_in;
      end
   end

endmodule

### sv/mft_queue.sv
`include "multi_fan_tachometer_assert.svh"

module mft_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mft_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output mft_pkg::job_type pop_job,
   output logic             empty
);
   import mft_pkg::*;

   job_type                   entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]   count_ff;
   logic [QUEUE_PTR_BITS:0]   count_in;

   assign full    = count_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign pop_job = entries_ff[rd_ptr_ff];

   // pointer and fill level
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   `MFT_ASSERT(a_no_overflow, clock, reset, !(push && full))
   `MFT_ASSERT(a_no_underflow, clock, reset, !(pop && empty))
   `MFT_ASSERT_ALWAYS(a_empty_after_reset, clock, reset |=> empty)

endmodule

### sv/mft_back.sv
`include "multi_fan_tachometer_assert.svh"

module mft_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [mft_pkg::NUM_W-1:0]   numerator,
   input  logic                        empty,
   input  mft_pkg::job_type            pop_job,
   output logic                        pop,
   mft_rsp_if.source                   rsp_bus
);
   import mft_pkg::*;

   localparam logic [DIV_STEP_BITS-1:0] LAST_STEP = DIV_STEP_BITS'(NUM_W - 1);

   back_state_type           state_ff;
   back_state_type           state_in;
   logic [NUM_W-1:0]         quo_ff;
   logic [NUM_W-1:0]         quo_in;
   logic [LIMIT_W-1:0]       rem_ff;
   logic [LIMIT_W-1:0]       rem_in;
   logic [LIMIT_W-1:0]       div_ff;
   logic [LIMIT_W-1:0]       div_in;
   logic [DIV_STEP_BITS-1:0] count_ff;
   logic [DIV_STEP_BITS-1:0] count_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic                     rsp_accepted_ff;
   logic                     rsp_accepted_in;
   logic [NUM_W-1:0]         rsp_rpm_ff;
   logic [NUM_W-1:0]         rsp_rpm_in;
   logic                     out_free;
   logic                     load_out;
   logic [LIMIT_W:0]         trial;
   logic [LIMIT_W:0]         diff;
   logic                     ge;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   // one restoring division step
   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign ge    = trial >= {1'b0, div_ff};

   // sequencer and divider
   always_comb begin
      state_in        = state_ff;
      quo_in          = quo_ff;
      rem_in          = rem_ff;
      div_in          = div_ff;
      count_in        = count_ff;
      pop             = 1'b0;
      load_out        = 1'b0;
      rsp_accepted_in = rsp_accepted_ff;
      rsp_rpm_in      = rsp_rpm_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (!empty) begin
               if (pop_job.rd_div) begin
                  pop      = 1'b1;
                  quo_in   = numerator;
                  rem_in   = '0;
                  div_in   = pop_job.divisor;
                  count_in = '0;
                  state_in = S_DIV;
               end else if (out_free) begin
                  pop             = 1'b1;
                  load_out        = 1'b1;
                  rsp_accepted_in = pop_job.accepted;
                  rsp_rpm_in      = '0;
               end
            end
         end
         S_DIV: begin
            rem_in   = ge ? diff[LIMIT_W-1:0] : trial[LIMIT_W-1:0];
            quo_in   = {quo_ff[NUM_W-2:0], ge};
            count_in = count_ff + 1'b1;
            if (count_ff == LAST_STEP) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               load_out        = 1'b1;
               rsp_accepted_in = 1'b0;
               rsp_rpm_in      = quo_ff;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff          <= quo_in;
      rem_ff          <= rem_in;
      div_ff          <= div_in;
      count_ff        <= count_in;
      rsp_accepted_ff <= rsp_accepted_in;
      rsp_rpm_ff      <= rsp_rpm_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.edge_accepted = rsp_accepted_ff;
   assign rsp_bus.rpm           = rsp_rpm_ff;

   `MFT_ASSERT(a_div_ends, clock, reset, state_ff == S_DIV && count_ff == LAST_STEP |=> state_ff == S_DONE)
   `MFT_ASSERT(a_no_pop_in_div, clock, reset, state_ff != S_IDLE |-> !pop)
   `MFT_ASSERT(a_read_rpm_no_accept, clock, reset, load_out && state_ff == S_DONE |=> !rsp_accepted_ff)

endmodule

### sv/multi_fan_tachometer.sv
// Speed monitor for up to five fans. Each edge transaction carries a fan index
// and a 48-bit microsecond timestamp; each read transaction a fan index and the
// current time. Every request gives exactly one response, in request order:
// edge_accepted for edges that pass the glitch filter, rpm for valid reads.
// The front end classifies and updates channel state in the cycle a request is
// taken and queues it; edges and rejected reads pass from the queue to the
// response register once it is free, and a valid read occupies the back-end
// divider, one quotient bit per cycle, for all 32 quotient bits. The
// two-entry queue takes up to two more requests while a division runs. Register
// writes through csr_ are taken at once and should be made only while idle.
module multi_fan_tachometer (
   input  logic                                clock,
   input  logic                                reset,
   mft_req_if.sink                             req_bus,
   mft_rsp_if.source                           rsp_bus,
   input  logic                                csr_we,
   input  logic [mft_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [mft_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import mft_pkg::*;

   logic [LIMIT_W-1:0] min_interval_ff;
   logic [LIMIT_W-1:0] min_interval_in;
   logic [LIMIT_W-1:0] max_age_ff;
   logic [LIMIT_W-1:0] max_age_in;
   logic [NUM_W-1:0]   numerator_ff;
   logic [NUM_W-1:0]   numerator_in;
   logic               push_valid;
   job_type            push_job;
   logic               queue_full;
   logic               pop;
   job_type            pop_job;
   logic               empty;

   // configuration registers
   always_comb begin
      min_interval_in = min_interval_ff;
      max_age_in      = max_age_ff;
      numerator_in    = numerator_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_INTERVAL: min_interval_in = csr_wdata[LIMIT_W-1:0];
            CSR_MAX_AGE:      max_age_in      = csr_wdata[LIMIT_W-1:0];
            CSR_NUMERATOR:    numerator_in    = csr_wdata[NUM_W-1:0];
            default: begin
               numerator_in = numerator_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_interval_ff <= MIN_INTERVAL_RESET;
         max_age_ff      <= MAX_AGE_RESET;
         numerator_ff    <= NUMERATOR_RESET;
      end else begin
         min_interval_ff <= min_interval_in;
         max_age_ff      <= max_age_in;
         numerator_ff    <= numerator_in;
      end
   end

   // classify and update channel state
   mft_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .min_interval (min_interval_ff),
      .max_age      (max_age_ff),
      .queue_full   (queue_full),
      .push_valid   (push_valid),
      .push_job     (push_job)
   );

   // decoupling queue
   mft_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push_valid),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .pop_job  (pop_job),
      .empty    (empty)
   );

   // divider and response register
   mft_back u_back (
      .clock     (clock),
      .reset     (reset),
      .numerator (numerator_ff),
      .empty     (empty),
      .pop_job   (pop_job),
      .pop       (pop),
      .rsp_bus   (rsp_bus)
   );

endmodule
